// ===== design/affine_fit_and_map_core_macros.svh =====
// ----------------------------------------------------------------------------
// Affine fit and map core assertion macros
// Shorthand for the clocked, reset-qualified checks of the core.
// ----------------------------------------------------------------------------
`ifndef AFFINE_FIT_AND_MAP_CORE_MACROS_SVH
`define AFFINE_FIT_AND_MAP_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/afm_pkg.sv =====
// ----------------------------------------------------------------------------
// Affine fit and map package
// Widths, codes, item types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afm_pkg;

  localparam int FIELD_W    = 16;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 24;
  localparam int COEF_W     = 48;
  localparam int HALF_W     = COEF_W / 2;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int DET_W      = 2 * DIFF_W + 1;
  localparam int ACC_A      = COEF_W + COORD_BITS + 2;
  localparam int ACC_B      = DET_W + FRAC_BITS + 1;
  localparam int ACC_W      = (ACC_A > ACC_B) ? ACC_A : ACC_B;
  localparam int CNT_W      = $clog2(ACC_W + 1);
  localparam int SLOT_N     = 3;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FIT  = 2'd1,
    OP_MAP  = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_NOMAT = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DET0, S_DET1, S_DCHK, S_NUM0, S_NUM1, S_ADIVS, S_ADIVW,
    S_NB0, S_BDIVS, S_BDIVW, S_NE0, S_NE1, S_NEW, S_MAP0, S_MAP1, S_MAPW, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    INIT_ZERO, INIT_T12, INIT_T1, INIT_E
  } init_sel_t;

  typedef enum logic [2:0] {
    M_DX12, M_DX13, M_T12, M_T13, M_A, M_B
  } m_sel_t;

  typedef enum logic [2:0] {
    N_DY12, N_DY13, N_DX12, N_X1, N_Y1, N_PX, N_PY
  } n_sel_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [1:0]               slot;
    logic signed [FIELD_W-1:0] src_x;
    logic signed [FIELD_W-1:0] src_y;
    logic signed [FIELD_W-1:0] dst_x;
    logic signed [FIELD_W-1:0] dst_y;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] mapped_x;
    logic signed [FIELD_W-1:0] mapped_y;
    logic [1:0]                status;
  } out_item_t;

  typedef struct packed {
    logic      accept;
    logic      load;
    logic      mac_en;
    logic      mac_init;
    init_sel_t init_sel;
    m_sel_t    m_sel;
    n_sel_t    n_sel;
    logic      mac_sub;
    logic      mac_hi;
    logic      det_wr;
    logic      div_start;
    logic      div_by_dy;
    logic      wr_a;
    logic      wr_b;
    logic      wr_e;
    logic      wr_map;
    logic      set_valid;
    logic      push;
    status_t   push_status;
    logic      row;
  } cmd_t;

  typedef struct packed {
    logic mat_valid;
    logic degen;
    logic div_done;
  } stat_t;

endpackage

// ===== design/afm_div.sv =====
// ----------------------------------------------------------------------------
// Affine fit and map divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [afm_pkg::ACC_W-1:0]   dvd_mag,
  input  logic [afm_pkg::DET_W-1:0]   dvs_mag,
  output logic                        done,
  output logic [afm_pkg::ACC_W-1:0]   quo
);

  logic                        busy_r;
  logic                        done_r;
  logic [afm_pkg::CNT_W-1:0]   cnt_r;
  logic [afm_pkg::DET_W-1:0]   rem_r;
  logic [afm_pkg::DET_W-1:0]   rem_nxt;
  logic [afm_pkg::DET_W-1:0]   dvs_r;
  logic [afm_pkg::ACC_W-1:0]   quo_r;
  logic [afm_pkg::ACC_W-1:0]   quo_nxt;
  logic [afm_pkg::DET_W:0]     rem_sh;
  logic                        ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[afm_pkg::ACC_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? afm_pkg::DET_W'(rem_sh - {1'b0, dvs_r})
                 : rem_sh[afm_pkg::DET_W-1:0];
    quo_nxt = {quo_r[afm_pkg::ACC_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= afm_pkg::CNT_W'(afm_pkg::ACC_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - afm_pkg::CNT_W'(1);
        if (cnt_r == afm_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dvd_mag;
      dvs_r <= dvs_mag;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== design/afm_dp.sv =====
// ----------------------------------------------------------------------------
// Affine fit and map datapath
// Point and coefficient storage, split multiply-accumulate, divider, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afm_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  afm_pkg::in_item_t  in_data,
  input  afm_pkg::cmd_t      cmd,
  output afm_pkg::stat_t     stat,
  output afm_pkg::out_item_t out_data
);

  logic signed [afm_pkg::COORD_BITS-1:0] sx_r [3];
  logic signed [afm_pkg::COORD_BITS-1:0] sy_r [3];
  logic signed [afm_pkg::COORD_BITS-1:0] tx_r [3];
  logic signed [afm_pkg::COORD_BITS-1:0] ty_r [3];
  logic signed [afm_pkg::COORD_BITS-1:0] px_r;
  logic signed [afm_pkg::COORD_BITS-1:0] py_r;
  logic signed [afm_pkg::COORD_BITS-1:0] rx_r;
  logic signed [afm_pkg::COORD_BITS-1:0] ry_r;
  logic signed [afm_pkg::COEF_W-1:0]     ca_r [2];
  logic signed [afm_pkg::COEF_W-1:0]     cb_r [2];
  logic signed [afm_pkg::COEF_W-1:0]     ce_r [2];
  logic signed [afm_pkg::ACC_W-1:0]      acc_r;
  logic signed [afm_pkg::ACC_W-1:0]      acc_nxt;
  logic signed [afm_pkg::DET_W-1:0]      det_r;
  logic                                  mv_r;
  logic                                  sat_r;
  logic                                  qneg_r;
  afm_pkg::out_item_t                    out_r;

  logic signed [afm_pkg::DIFF_W-1:0] dx12, dx13, dy12, dy13, t12, t13;
  logic signed [afm_pkg::COORD_BITS-1:0] t1, t2, t3;
  logic signed [afm_pkg::COEF_W-1:0] m_op;
  logic signed [afm_pkg::DIFF_W-1:0] n_op;
  logic [afm_pkg::HALF_W-1:0] m_lo;
  logic signed [afm_pkg::COEF_W-afm_pkg::HALF_W-1:0] m_hi;
  logic signed [afm_pkg::HALF_W+afm_pkg::DIFF_W:0] prod_lo;
  logic signed [afm_pkg::COEF_W-afm_pkg::HALF_W+afm_pkg::DIFF_W-1:0] prod_hi;
  logic signed [afm_pkg::ACC_W-1:0] term, base, init_val;
  logic signed [afm_pkg::ACC_W-1:0] dvd_src;
  logic signed [afm_pkg::DET_W-1:0] dvs_src;
  logic [afm_pkg::ACC_W-1:0] dvd_mag, div_quo;
  logic [afm_pkg::DET_W-1:0] dvs_mag;
  logic div_done;
  logic acc_neg;
  logic [afm_pkg::ACC_W-1:0] acc_mag, ish, lim_c;
  logic csat;
  logic [afm_pkg::COORD_BITS-1:0] cv;
  logic [afm_pkg::COEF_W:0] qs, es;
  afm_pkg::status_t push_st;

  function automatic logic signed [afm_pkg::COORD_BITS-1:0] to_coord(
    input logic [afm_pkg::FIELD_W-1:0] f
  );
    return afm_pkg::COORD_BITS'(f);
  endfunction

  // Saturates a magnitude and sign to the coefficient range; top bit flags clipping.
  function automatic logic [afm_pkg::COEF_W:0] sat_coef(
    input logic [afm_pkg::ACC_W-1:0] mag,
    input logic                      neg
  );
    logic [afm_pkg::ACC_W-1:0] lim;
    logic [afm_pkg::COEF_W-1:0] v;
    logic s;
    lim = (afm_pkg::ACC_W'(1) << (afm_pkg::COEF_W - 1)) - afm_pkg::ACC_W'(!neg);
    s   = mag > lim;
    v   = s ? lim[afm_pkg::COEF_W-1:0] : mag[afm_pkg::COEF_W-1:0];
    if (neg) begin
      v = -v;
    end
    return {s, v};
  endfunction

  assign t1 = cmd.row ? ty_r[0] : tx_r[0];
  assign t2 = cmd.row ? ty_r[1] : tx_r[1];
  assign t3 = cmd.row ? ty_r[2] : tx_r[2];

  assign dx12 = afm_pkg::DIFF_W'(sx_r[0]) - afm_pkg::DIFF_W'(sx_r[1]);
  assign dx13 = afm_pkg::DIFF_W'(sx_r[0]) - afm_pkg::DIFF_W'(sx_r[2]);
  assign dy12 = afm_pkg::DIFF_W'(sy_r[0]) - afm_pkg::DIFF_W'(sy_r[1]);
  assign dy13 = afm_pkg::DIFF_W'(sy_r[0]) - afm_pkg::DIFF_W'(sy_r[2]);
  assign t12  = afm_pkg::DIFF_W'(t1) - afm_pkg::DIFF_W'(t2);
  assign t13  = afm_pkg::DIFF_W'(t1) - afm_pkg::DIFF_W'(t3);

  always_comb begin
    unique case (cmd.m_sel)
      afm_pkg::M_DX12: m_op = afm_pkg::COEF_W'(dx12);
      afm_pkg::M_DX13: m_op = afm_pkg::COEF_W'(dx13);
      afm_pkg::M_T12:  m_op = afm_pkg::COEF_W'(t12);
      afm_pkg::M_T13:  m_op = afm_pkg::COEF_W'(t13);
      afm_pkg::M_A:    m_op = ca_r[cmd.row];
      afm_pkg::M_B:    m_op = cb_r[cmd.row];
      default:         m_op = '0;
    endcase
    unique case (cmd.n_sel)
      afm_pkg::N_DY12: n_op = dy12;
      afm_pkg::N_DY13: n_op = dy13;
      afm_pkg::N_DX12: n_op = dx12;
      afm_pkg::N_X1:   n_op = afm_pkg::DIFF_W'(sx_r[0]);
      afm_pkg::N_Y1:   n_op = afm_pkg::DIFF_W'(sy_r[0]);
      afm_pkg::N_PX:   n_op = afm_pkg::DIFF_W'(px_r);
      afm_pkg::N_PY:   n_op = afm_pkg::DIFF_W'(py_r);
      default:         n_op = '0;
    endcase
    unique case (cmd.init_sel)
      afm_pkg::INIT_ZERO: init_val = '0;
      afm_pkg::INIT_T12:  init_val = afm_pkg::ACC_W'(t12) <<< afm_pkg::FRAC_BITS;
      afm_pkg::INIT_T1:   init_val = afm_pkg::ACC_W'(t1) <<< afm_pkg::FRAC_BITS;
      afm_pkg::INIT_E:    init_val = afm_pkg::ACC_W'(ce_r[cmd.row]);
      default:            init_val = '0;
    endcase
  end

  // The coefficient operand is taken in two halves on successive cycles.
  assign m_lo    = m_op[afm_pkg::HALF_W-1:0];
  assign m_hi    = m_op[afm_pkg::COEF_W-1:afm_pkg::HALF_W];
  assign prod_lo = $signed({1'b0, m_lo}) * n_op;
  assign prod_hi = m_hi * n_op;
  assign term    = cmd.mac_hi ? (afm_pkg::ACC_W'(prod_hi) <<< afm_pkg::HALF_W)
                              : afm_pkg::ACC_W'(prod_lo);
  assign base    = cmd.mac_init ? init_val : acc_r;
  assign acc_nxt = cmd.mac_sub ? base - term : base + term;

  assign dvd_src = cmd.div_by_dy ? acc_r : (acc_r <<< afm_pkg::FRAC_BITS);
  assign dvs_src = cmd.div_by_dy ? afm_pkg::DET_W'(dy12) : det_r;
  assign dvd_mag = dvd_src[afm_pkg::ACC_W-1] ? afm_pkg::ACC_W'(-dvd_src)
                                              : afm_pkg::ACC_W'(dvd_src);
  assign dvs_mag = dvs_src[afm_pkg::DET_W-1] ? afm_pkg::DET_W'(-dvs_src)
                                              : afm_pkg::DET_W'(dvs_src);

  afm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dvd_mag (dvd_mag),
    .dvs_mag (dvs_mag),
    .done    (div_done),
    .quo     (div_quo)
  );

  always_comb begin
    acc_neg = acc_r[afm_pkg::ACC_W-1];
    acc_mag = acc_neg ? afm_pkg::ACC_W'(-acc_r) : afm_pkg::ACC_W'(acc_r);
    ish     = acc_mag >> afm_pkg::FRAC_BITS;
    lim_c   = (afm_pkg::ACC_W'(1) << (afm_pkg::COORD_BITS - 1)) - afm_pkg::ACC_W'(!acc_neg);
    csat    = ish > lim_c;
    cv      = csat ? lim_c[afm_pkg::COORD_BITS-1:0] : ish[afm_pkg::COORD_BITS-1:0];
    if (acc_neg) begin
      cv = -cv;
    end
    qs = sat_coef(div_quo, qneg_r);
    es = sat_coef(acc_mag, acc_neg);
    push_st = (cmd.push_status == afm_pkg::ST_OK && sat_r) ? afm_pkg::ST_SAT
                                                           : cmd.push_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < afm_pkg::SLOT_N; i++) begin
        sx_r[i] <= '0;
        sy_r[i] <= '0;
        tx_r[i] <= '0;
        ty_r[i] <= '0;
      end
      mv_r <= 1'b0;
    end else begin
      if (cmd.load && in_data.slot < 2'(afm_pkg::SLOT_N)) begin
        sx_r[in_data.slot] <= to_coord(in_data.src_x);
        sy_r[in_data.slot] <= to_coord(in_data.src_y);
        tx_r[in_data.slot] <= to_coord(in_data.dst_x);
        ty_r[in_data.slot] <= to_coord(in_data.dst_y);
      end
      if (cmd.set_valid) begin
        mv_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r  <= to_coord(in_data.src_x);
      py_r  <= to_coord(in_data.src_y);
      rx_r  <= '0;
      ry_r  <= '0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.wr_a || cmd.wr_b) begin
        sat_r <= sat_r | qs[afm_pkg::COEF_W];
      end else if (cmd.wr_e) begin
        sat_r <= sat_r | es[afm_pkg::COEF_W];
      end else if (cmd.wr_map) begin
        sat_r <= sat_r | csat;
      end
      if (cmd.wr_map) begin
        if (cmd.row) begin
          ry_r <= cv;
        end else begin
          rx_r <= cv;
        end
      end
    end
    if (cmd.mac_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.det_wr) begin
      det_r <= acc_r[afm_pkg::DET_W-1:0];
    end
    if (cmd.div_start) begin
      qneg_r <= dvd_src[afm_pkg::ACC_W-1] ^ dvs_src[afm_pkg::DET_W-1];
    end
    if (cmd.wr_a) begin
      ca_r[cmd.row] <= qs[afm_pkg::COEF_W-1:0];
    end
    if (cmd.wr_b) begin
      cb_r[cmd.row] <= qs[afm_pkg::COEF_W-1:0];
    end
    if (cmd.wr_e) begin
      ce_r[cmd.row] <= es[afm_pkg::COEF_W-1:0];
    end
    if (cmd.push) begin
      out_r.mapped_x <= afm_pkg::FIELD_W'($unsigned(rx_r));
      out_r.mapped_y <= afm_pkg::FIELD_W'($unsigned(ry_r));
      out_r.status   <= push_st;
    end
  end

  assign stat.mat_valid = mv_r;
  assign stat.degen     = (acc_r == '0) || (dy12 == '0);
  assign stat.div_done  = div_done;
  assign out_data       = out_r;

endmodule

// ===== design/afm_ctl.sv =====
// ----------------------------------------------------------------------------
// Affine fit and map controller
// Sequences fit and map steps and owns the channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afm_ctl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_opcode,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  afm_pkg::stat_t stat,
  output afm_pkg::cmd_t  cmd
);

  afm_pkg::state_t  state_r, state_nxt;
  afm_pkg::status_t stt_r, stt_nxt;
  logic             ph_r, ph_nxt;
  logic             row_r, row_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= afm_pkg::S_IDLE;
      stt_r       <= afm_pkg::ST_OK;
      ph_r        <= 1'b0;
      row_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stt_r       <= stt_nxt;
      ph_r        <= ph_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    stt_nxt       = stt_r;
    ph_nxt        = ph_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.row       = row_r;
    cmd.mac_hi    = ph_r;

    unique case (state_r)
      afm_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.load   = (in_opcode == afm_pkg::OP_LOAD);
          row_nxt    = 1'b0;
          ph_nxt     = 1'b0;
          stt_nxt    = afm_pkg::ST_OK;
          if (in_opcode == afm_pkg::OP_FIT) begin
            state_nxt = afm_pkg::S_DET0;
          end else if (in_opcode == afm_pkg::OP_MAP) begin
            if (stat.mat_valid) begin
              state_nxt = afm_pkg::S_MAP0;
            end else begin
              stt_nxt   = afm_pkg::ST_NOMAT;
              state_nxt = afm_pkg::S_DONE;
            end
          end
        end
      end
      afm_pkg::S_DET0: begin
        cmd.mac_en   = 1'b1;
        cmd.mac_init = !ph_r;
        cmd.init_sel = afm_pkg::INIT_ZERO;
        cmd.m_sel    = afm_pkg::M_DX12;
        cmd.n_sel    = afm_pkg::N_DY13;
        ph_nxt       = !ph_r;
        if (ph_r) state_nxt = afm_pkg::S_DET1;
      end
      afm_pkg::S_DET1: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sub = 1'b1;
        cmd.m_sel   = afm_pkg::M_DX13;
        cmd.n_sel   = afm_pkg::N_DY12;
        ph_nxt      = !ph_r;
        if (ph_r) state_nxt = afm_pkg::S_DCHK;
      end
      afm_pkg::S_DCHK: begin
        cmd.det_wr = 1'b1;
        if (stat.degen) begin
          stt_nxt   = afm_pkg::ST_DEGEN;
          state_nxt = afm_pkg::S_DONE;
        end else begin
          state_nxt = afm_pkg::S_NUM0;
        end
      end
      afm_pkg::S_NUM0: begin
        cmd.mac_en   = 1'b1;
        cmd.mac_init = !ph_r;
        cmd.init_sel = afm_pkg::INIT_ZERO;
        cmd.m_sel    = afm_pkg::M_T12;
        cmd.n_sel    = afm_pkg::N_DY13;
        ph_nxt       = !ph_r;
        if (ph_r) state_nxt = afm_pkg::S_NUM1;
      end
      afm_pkg::S_NUM1: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sub = 1'b1;
        cmd.m_sel   = afm_pkg::M_T13;
        cmd.n_sel   = afm_pkg::N_DY12;
        ph_nxt      = !ph_r;
        if (ph_r) state_nxt = afm_pkg::S_ADIVS;
      end
      afm_pkg::S_ADIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = afm_pkg::S_ADIVW;
      end
      afm_pkg::S_ADIVW: begin
        if (stat.div_done) begin
          cmd.wr_a  = 1'b1;
          state_nxt = afm_pkg::S_NB0;
        end
      end
      afm_pkg::S_NB0: begin
        cmd.mac_en   = 1'b1;
        cmd.mac_init = !ph_r;
        cmd.mac_sub  = 1'b1;
        cmd.init_sel = afm_pkg::INIT_T12;
        cmd.m_sel    = afm_pkg::M_A;
        cmd.n_sel    = afm_pkg::N_DX12;
        ph_nxt       = !ph_r;
        if (ph_r) state_nxt = afm_pkg::S_BDIVS;
      end
      afm_pkg::S_BDIVS: begin
        cmd.div_start = 1'b1;
        cmd.div_by_dy = 1'b1;
        state_nxt     = afm_pkg::S_BDIVW;
      end
      afm_pkg::S_BDIVW: begin
        if (stat.div_done) begin
          cmd.wr_b  = 1'b1;
          state_nxt = afm_pkg::S_NE0;
        end
      end
      afm_pkg::S_NE0: begin
        cmd.mac_en   = 1'b1;
        cmd.mac_init = !ph_r;
        cmd.mac_sub  = 1'b1;
        cmd.init_sel = afm_pkg::INIT_T1;
        cmd.m_sel    = afm_pkg::M_A;
        cmd.n_sel    = afm_pkg::N_X1;
        ph_nxt       = !ph_r;
        if (ph_r) state_nxt = afm_pkg::S_NE1;
      end
      afm_pkg::S_NE1: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sub = 1'b1;
        cmd.m_sel   = afm_pkg::M_B;
        cmd.n_sel   = afm_pkg::N_Y1;
        ph_nxt      = !ph_r;
        if (ph_r) state_nxt = afm_pkg::S_NEW;
      end
      afm_pkg::S_NEW: begin
        cmd.wr_e = 1'b1;
        if (row_r) begin
          cmd.set_valid = 1'b1;
          state_nxt     = afm_pkg::S_DONE;
        end else begin
          row_nxt   = 1'b1;
          state_nxt = afm_pkg::S_NUM0;
        end
      end
      afm_pkg::S_MAP0: begin
        cmd.mac_en   = 1'b1;
        cmd.mac_init = !ph_r;
        cmd.init_sel = afm_pkg::INIT_E;
        cmd.m_sel    = afm_pkg::M_A;
        cmd.n_sel    = afm_pkg::N_PX;
        ph_nxt       = !ph_r;
        if (ph_r) state_nxt = afm_pkg::S_MAP1;
      end
      afm_pkg::S_MAP1: begin
        cmd.mac_en = 1'b1;
        cmd.m_sel  = afm_pkg::M_B;
        cmd.n_sel  = afm_pkg::N_PY;
        ph_nxt     = !ph_r;
        if (ph_r) state_nxt = afm_pkg::S_MAPW;
      end
      afm_pkg::S_MAPW: begin
        cmd.wr_map = 1'b1;
        if (row_r) begin
          state_nxt = afm_pkg::S_DONE;
        end else begin
          row_nxt   = 1'b1;
          state_nxt = afm_pkg::S_MAP0;
        end
      end
      afm_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.push        = 1'b1;
          cmd.push_status = stt_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = afm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = afm_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != afm_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/affine_fit_and_map_core.sv =====
// A load writes its point pair into the point registers on acceptance and gives no item.
// A map item runs MAP0, MAP1 and MAPW for each row, then DONE raises out_valid.
// A fit runs four serial divisions, two per row, each giving a 66-bit quotient.
// Throughput: one item in flight; a finished item waits in the output register.
// Reset: rst_n synchronous, active low; clears points, the matrix valid flag and control.
`timescale 1ns / 1ps
`include "affine_fit_and_map_core_macros.svh"

// ----------------------------------------------------------------------------
// Affine fit and map core
// Fits a 2D affine map from three point pairs and maps points through it.
// ----------------------------------------------------------------------------
//
// The controller accepts one item whenever it is idle. Load items write one
// source/target pair. A fit item first forms the determinant on the shared
// multiply-accumulate unit; if it or y1-y2 is zero the fit is reported as
// degenerate and the stored matrix is untouched. Otherwise each row runs
// numerator, divide by determinant (a), the b numerator, divide by y1-y2 (b),
// and the offset e, with saturation to the coefficient range.
//
// A map item runs e + a*x + b*y for each row. Every 48-bit by 17-bit product
// is taken as two half products on consecutive cycles into one accumulator,
// and the result is truncated toward zero and saturated to the coordinate
// range. The result goes into an output register so the controller can take
// the next item while the result is still waiting on the output side.

module affine_fit_and_map_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  afm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output afm_pkg::out_item_t out_data
);

  afm_pkg::cmd_t  cmd;
  afm_pkg::stat_t stat;

  afm_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  afm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // A fit item keeps the input side busy on the very next cycle.
  `AFM_ASSERT_NEXT(a_fit_blocks_input, in_valid && !in_stall && (in_data.opcode == afm_pkg::OP_FIT), in_stall, "fit item did not occupy the core")
  // A new result only appears after the core was busy.
  `AFM_ASSERT_NOW(a_result_after_busy, $rose(out_valid), $past(in_stall), "result appeared from idle")
  // A load item never produces a result.
  `AFM_ASSERT_NEXT(a_load_no_result, in_valid && !in_stall && (in_data.opcode == afm_pkg::OP_LOAD), !$rose(out_valid), "load item produced a result")

endmodule
